### rtl/ses_pkg.sv
// Shared types and constants for the streaming Sobel edge block.
// Holds the result record, the control state encoding, register indexes and the bias helper.
// No dependencies.
package ses_pkg;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int COORD_W   = 10;
   localparam int ROOT_IN_W = 16;
   localparam int ROOT_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int MIN_DIM   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd300;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd200;

   // 127 * 8: centers a gradient of -1020..1020 on the 8-bit range
   localparam logic signed [12:0] GRAD_BIAS = 13'sd1016;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_GRAD = 5'b00010,
      S_SQR  = 5'b00100,
      S_ROOT = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   gx;
      logic [PIX_W-1:0]   gy;
      logic [PIX_W-1:0]   mag;
      logic               eof;
   } res_type;

   // max(0, floor((g + 1016) / 8)); the sum never exceeds 2036
   function automatic logic [PIX_W-1:0] grad_bias(input logic signed [11:0] g);
      logic signed [12:0] s;
      s = {g[11], g} + GRAD_BIAS;
      return s[12] ? '0 : s[10:3];
   endfunction

endpackage

### rtl/ses_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ses_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ses_isqrt.sv
// Iterative floor square root of a 16-bit value, one result bit per cycle.
// Depends on ses_pkg.
module ses_isqrt import ses_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ROOT_IN_W-1:0] operand,
   output logic                 done,
   output logic [ROOT_W-1:0]    root
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [2:0]           step_ff, step_in;
   logic [ROOT_IN_W-1:0] x_ff, x_in;
   logic [ROOT_IN_W-1:0] r_ff, r_in;
   logic [ROOT_IN_W-1:0] op_ff, op_in;
   logic [ROOT_IN_W-1:0] bit_val;
   logic [ROOT_IN_W:0]   trial;
   logic [ROOT_IN_W:0]   sq_lo;
   logic [ROOT_IN_W:0]   sq_hi;

   assign bit_val = ROOT_IN_W'(1) << {step_ff, 1'b0};
   assign trial   = {1'b0, r_ff} + {1'b0, bit_val};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      op_in   = op_ff;
      if (busy_ff) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in = x_ff - trial[ROOT_IN_W-1:0];
            r_in = (r_ff >> 1) + bit_val;
         end else begin
            r_in = r_ff >> 1;
         end
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         step_in = 3'd7;
         x_in    = operand;
         r_in    = '0;
         op_in   = operand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      r_ff  <= r_in;
      op_ff <= op_in;
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

   assign sq_lo = (ROOT_IN_W+1)'(root) * (ROOT_IN_W+1)'(root);
   assign sq_hi = ((ROOT_IN_W+1)'(root) + 17'd1) * ((ROOT_IN_W+1)'(root) + 17'd1);

   a_root_exact: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (sq_lo <= {1'b0, op_ff}) && (sq_hi > {1'b0, op_ff}))
      else $error("square root result out of bounds");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff && (step_ff == 3'd7))
      else $error("square root did not start");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("square root done without a run");

endmodule

### rtl/sobel_edge_stream.sv
// Streaming 3x3 Sobel edge block: two line-store RAMs, a two-column window, iterative root.
// Each item passes through a RAM read and the gradient step, then for an interior pixel
// the squares and the 8-step square root, then one result per cycle (0 to 3) into the
// output register while the output does not stall. A new pixel is accepted only once the
// previous item has released all its results; output stalls hold the item.
// Reset clears control, position counters, window and sizes (300 x 200);
// line stores are not cleared.
// Depends on ses_pkg, ses_ram, ses_isqrt.
module sobel_edge_stream import ses_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 req_start_of_frame,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COORD_W-1:0]   rsp_out_row,
   output logic [COORD_W-1:0]   rsp_out_col,
   output logic [PIX_W-1:0]     rsp_grad_x_biased,
   output logic [PIX_W-1:0]     rsp_grad_y_biased,
   output logic [PIX_W-1:0]     rsp_magnitude,
   output logic                 rsp_last_of_run,
   output logic                 rsp_end_of_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int DW  = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
   localparam int DH  = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
   localparam int CXW = (CW > COORD_W) ? CW : COORD_W;
   localparam int RXW = (RW > COORD_W) ? RW : COORD_W;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   frame_width_ff, frame_width_in;
   logic [CFG_W-1:0]   frame_height_ff, frame_height_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_q_ff, row_q_in;
   logic [CW-1:0]      col_q_ff, col_q_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [47:0]        window_ff, window_in;
   logic [PIX_W-1:0]   bx_ff, bx_in;
   logic [PIX_W-1:0]   by_ff, by_in;
   logic [15:0]        sqx_ff, sqx_in;
   logic [15:0]        sqy_ff, sqy_in;
   logic               start_ff, start_in;
   res_type            slot_ff [3];
   res_type            slot_in [3];
   logic [2:0]         pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [DW-1:0]      w_raw, w_dim;
   logic [DH-1:0]      h_raw, h_dim;
   logic               accept;
   logic               restart;
   logic [CW-1:0]      col_start;
   logic [PIX_W-1:0]   ur, mr;
   logic [PIX_W-1:0]   u1, m1, l1, u2, m2, l2;
   logic [9:0]         left_sum, right_sum, top_sum, bot_sum;
   logic signed [11:0] gx, gy;
   logic               has_prev, interior, w_last, h_last;
   logic [RXW-1:0]     row_prev_x, row_cur_x;
   logic [CXW-1:0]     col_prev_x, col_cur_x;
   res_type            slot_new [3];
   logic [2:0]         pend_new;
   logic [DW-1:0]      col_inc;
   logic [DH-1:0]      row_inc;
   logic               emit_go;
   logic [1:0]         sel;
   logic [2:0]         sel_mask;
   logic [2:0]         pend_rest;
   logic [ROOT_IN_W:0] sq_sum;
   logic               root_done;
   logic [ROOT_W-1:0]  root;

   // clamp sizes to 3..MAX
   always_comb begin
      w_raw = DW'(frame_width_ff);
      h_raw = DH'(frame_height_ff);
      w_dim = w_raw;
      h_dim = h_raw;
      if (w_raw < DW'(MIN_DIM)) begin
         w_dim = DW'(MIN_DIM);
      end else if (w_raw > DW'(MAX_WIDTH)) begin
         w_dim = DW'(MAX_WIDTH);
      end
      if (h_raw < DH'(MIN_DIM)) begin
         h_dim = DH'(MIN_DIM);
      end else if (h_raw > DH'(MAX_HEIGHT)) begin
         h_dim = DH'(MAX_HEIGHT);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // a pixel outside the current frame starts a new one
   assign restart   = req_start_of_frame || (DH'(row_ff) >= h_dim) || (DW'(col_ff) >= w_dim);
   assign col_start = restart ? '0 : col_ff;

   ses_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (state_ff == S_GRAD),
      .wr_addr (col_q_ff),
      .wr_data (mr),
      .rd_en   (accept),
      .rd_addr (col_start),
      .rd_data (ur)
   );

   ses_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (state_ff == S_GRAD),
      .wr_addr (col_q_ff),
      .wr_data (pix_ff),
      .rd_en   (accept),
      .rd_addr (col_start),
      .rd_data (mr)
   );

   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   ses_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .operand (sq_sum[ROOT_IN_W:1]),
      .done    (root_done),
      .root    (root)
   );

   // window: column one back in [23:0], two back in [47:24], each {upper, middle, lower}
   assign u1 = window_ff[23:16];
   assign m1 = window_ff[15:8];
   assign l1 = window_ff[7:0];
   assign u2 = window_ff[47:40];
   assign m2 = window_ff[39:32];
   assign l2 = window_ff[31:24];

   assign left_sum  = {2'b0, u2} + {1'b0, m2, 1'b0} + {2'b0, l2};
   assign right_sum = {2'b0, ur} + {1'b0, mr, 1'b0} + {2'b0, pix_ff};
   assign top_sum   = {2'b0, u2} + {1'b0, u1, 1'b0} + {2'b0, ur};
   assign bot_sum   = {2'b0, l2} + {1'b0, l1, 1'b0} + {2'b0, pix_ff};
   assign gx = $signed({2'b0, left_sum}) - $signed({2'b0, right_sum});
   assign gy = $signed({2'b0, top_sum}) - $signed({2'b0, bot_sum});

   assign has_prev = (row_q_ff != '0);
   assign interior = (row_q_ff >= RW'(2)) && (col_q_ff >= CW'(2));
   assign w_last   = (DW'(col_q_ff) == w_dim - DW'(1));
   assign h_last   = (DH'(row_q_ff) == h_dim - DH'(1));

   assign row_prev_x = RXW'(row_q_ff - RW'(1));
   assign row_cur_x  = RXW'(row_q_ff);
   assign col_prev_x = CXW'(col_q_ff - CW'(1));
   assign col_cur_x  = CXW'(col_q_ff);

   always_comb begin
      slot_new[0] = '{row: row_prev_x[COORD_W-1:0], col: col_prev_x[COORD_W-1:0],
                      gx: interior ? grad_bias(gx) : m1,
                      gy: interior ? grad_bias(gy) : m1,
                      mag: m1, eof: 1'b0};
      slot_new[1] = '{row: row_prev_x[COORD_W-1:0], col: col_cur_x[COORD_W-1:0],
                      gx: mr, gy: mr, mag: mr, eof: 1'b0};
      slot_new[2] = '{row: row_cur_x[COORD_W-1:0], col: col_cur_x[COORD_W-1:0],
                      gx: pix_ff, gy: pix_ff, mag: pix_ff, eof: w_last};
      pend_new    = {h_last, has_prev && w_last, has_prev && (col_q_ff != '0)};
   end

   assign col_inc = DW'(col_q_ff) + DW'(1);
   assign row_inc = DH'(row_q_ff) + DH'(1);

   // lowest pending result goes out first
   always_comb begin
      if (pend_ff[0]) begin
         sel = 2'd0;
      end else if (pend_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      sel_mask  = 3'b001 << sel;
      pend_rest = pend_ff & ~sel_mask;
   end

   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      row_q_in        = row_q_ff;
      col_q_in        = col_q_ff;
      pix_in          = pix_ff;
      window_in       = window_ff;
      bx_in           = bx_ff;
      by_in           = by_ff;
      sqx_in          = sqx_ff;
      sqy_in          = sqy_ff;
      start_in        = 1'b0;
      slot_in         = slot_ff;
      pend_in         = pend_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               row_q_in = restart ? '0 : row_ff;
               col_q_in = col_start;
               pix_in   = req_pixel;
               state_in = S_GRAD;
            end
         end
         S_GRAD: begin
            bx_in     = grad_bias(gx);
            by_in     = grad_bias(gy);
            slot_in   = slot_new;
            pend_in   = pend_new;
            window_in = {window_ff[23:0], ur, mr, pix_ff};
            if (col_inc >= w_dim) begin
               col_in = '0;
               row_in = (row_inc >= h_dim) ? '0 : row_q_ff + RW'(1);
            end else begin
               col_in = col_q_ff + CW'(1);
               row_in = row_q_ff;
            end
            if (interior) begin
               state_in = S_SQR;
            end else if (pend_new != 3'b0) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQR: begin
            sqx_in   = 16'(bx_ff) * 16'(bx_ff);
            sqy_in   = 16'(by_ff) * 16'(by_ff);
            start_in = 1'b1;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               slot_in[0].mag = root;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = slot_ff[sel];
               rsp_last_in  = (pend_rest == 3'b0);
               pend_in      = pend_rest;
               if (pend_rest == 3'b0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         row_ff          <= '0;
         col_ff          <= '0;
         window_ff       <= '0;
         start_ff        <= 1'b0;
         pend_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         window_ff       <= window_in;
         start_ff        <= start_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_q_ff    <= row_q_in;
      col_q_ff    <= col_q_in;
      pix_ff      <= pix_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_data_ff.row;
   assign rsp_out_col       = rsp_data_ff.col;
   assign rsp_grad_x_biased = rsp_data_ff.gx;
   assign rsp_grad_y_biased = rsp_data_ff.gy;
   assign rsp_magnitude     = rsp_data_ff.mag;
   assign rsp_end_of_frame  = rsp_data_ff.eof;
   assign rsp_last_of_run   = rsp_last_ff;

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (pend_ff != 3'b0))
      else $error("emit state with nothing pending");

   a_root_in_root_state: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_ROOT))
      else $error("square root finished outside its state");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      emit_go && (pend_rest == 3'b0) |=> (state_ff == S_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final result did not close the item");

endmodule

### sim/sobel_edge_stream_checker.sv
// Checker for sobel_edge_stream: watches the pixel, result and register channels,
// predicts the results of every accepted pixel item and compares them in order.
// Depends on ses_pkg for widths and register indexes.
module sobel_edge_stream_checker import ses_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 req_start_of_frame,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [COORD_W-1:0]   rsp_out_row,
   input  logic [COORD_W-1:0]   rsp_out_col,
   input  logic [PIX_W-1:0]     rsp_grad_x_biased,
   input  logic [PIX_W-1:0]     rsp_grad_y_biased,
   input  logic [PIX_W-1:0]     rsp_magnitude,
   input  logic                 rsp_last_of_run,
   input  logic                 rsp_end_of_frame,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   expected_left,
   output int                   pixels_seen,
   output int                   results_seen,
   output int                   frame_ends
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   gx;
      logic [PIX_W-1:0]   gy;
      logic [PIX_W-1:0]   mag;
      logic               last;
      logic               eof;
   } edge_result_type;

   edge_result_type   pending_results[$];
   bit [PIX_W-1:0]    upper_line[MAX_WIDTH];
   bit [PIX_W-1:0]    middle_line[MAX_WIDTH];
   bit [6*PIX_W-1:0]  window;
   int unsigned       pos_row;
   int unsigned       pos_col;
   bit [CFG_W-1:0]    width_reg;
   bit [CFG_W-1:0]    height_reg;
   int                report_lines;

   initial begin
      fail_count    = 0;
      expected_left = 0;
      pixels_seen   = 0;
      results_seen  = 0;
      frame_ends    = 0;
      report_lines  = 0;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int biased(int g);
      int s;
      s = g + 1016;
      if (s < 0) return 0;
      return s / 8;
   endfunction

   function automatic int floor_sqrt(int x);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= x) r++;
      return r;
   endfunction

   function automatic edge_result_type make_result(int unsigned row, int unsigned col,
                                                   int gx, int gy, int mag, bit eof);
      edge_result_type r;
      r.row  = row[COORD_W-1:0];
      r.col  = col[COORD_W-1:0];
      r.gx   = gx[PIX_W-1:0];
      r.gy   = gy[PIX_W-1:0];
      r.mag  = mag[PIX_W-1:0];
      r.last = 1'b0;
      r.eof  = eof;
      return r;
   endfunction

   // Run one pixel through the window and queue the 0 to 3 results it releases.
   task automatic predict_pixel(input bit [PIX_W-1:0] p, input bit sof);
      int unsigned  w, h, row, col;
      bit [PIX_W-1:0] ur, mr, u1, m1, l1, u2, m2, l2;
      int           gx, gy, bx, by, n;
      edge_result_type made[3];
      edge_result_type r;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      row = pos_row;
      col = pos_col;
      n = 0;
      // restart on a frame mark, or when a smaller frame leaves us outside it
      if (sof || row >= h || col >= w) begin
         row = 0;
         col = 0;
      end
      ur = upper_line[col];
      mr = middle_line[col];
      u1 = window[3*PIX_W-1:2*PIX_W];
      m1 = window[2*PIX_W-1:PIX_W];
      l1 = window[PIX_W-1:0];
      u2 = window[6*PIX_W-1:5*PIX_W];
      m2 = window[5*PIX_W-1:4*PIX_W];
      l2 = window[4*PIX_W-1:3*PIX_W];

      if (row >= 1 && col >= 1) begin
         if (row >= 2 && col >= 2) begin
            gx = int'(u2) + 2 * int'(m2) + int'(l2) - int'(ur) - 2 * int'(mr) - int'(p);
            gy = int'(u2) + 2 * int'(u1) + int'(ur) - int'(l2) - 2 * int'(l1) - int'(p);
            bx = biased(gx);
            by = biased(gy);
            made[n] = make_result(row - 1, col - 1, bx, by, floor_sqrt((bx * bx + by * by) / 2),
                                  1'b0);
         end else begin
            made[n] = make_result(row - 1, col - 1, m1, m1, m1, 1'b0);
         end
         n++;
      end
      if (row >= 1 && col == w - 1) begin
         made[n] = make_result(row - 1, col, mr, mr, mr, 1'b0);
         n++;
      end
      if (row == h - 1) begin
         made[n] = make_result(row, col, p, p, p, col == w - 1);
         n++;
      end
      for (int i = 0; i < n; i++) begin
         r = made[i];
         r.last = (i == n - 1);
         pending_results.push_back(r);
      end

      upper_line[col]  = mr;
      middle_line[col] = p;
      window = {window[3*PIX_W-1:0], ur, mr, p};

      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      pos_row = row;
      pos_col = col;
   endtask

   function automatic bit field_bad(string name, logic [15:0] want, logic [15:0] got);
      if (got === want) return 1'b0;
      if (report_lines < MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      report_lines++;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      edge_result_type want;
      bit bad;
      if (reset) begin
         pending_results.delete();
         window     = '0;
         pos_row    = 0;
         pos_col    = 0;
         width_reg  = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_end_of_frame === 1'b1) frame_ends++;
            if (pending_results.size() == 0) begin
               fail_count++;
               if (report_lines < MAX_REPORTS)
                  $display("%0t: unexpected result, row %0d col %0d", $time, rsp_out_row,
                           rsp_out_col);
               report_lines++;
            end else begin
               want = pending_results.pop_front();
               bad = field_bad("out_row", want.row, rsp_out_row)
                   | field_bad("out_col", want.col, rsp_out_col)
                   | field_bad("grad_x_biased", want.gx, rsp_grad_x_biased)
                   | field_bad("grad_y_biased", want.gy, rsp_grad_y_biased)
                   | field_bad("magnitude", want.mag, rsp_magnitude)
                   | field_bad("last_of_run", want.last, rsp_last_of_run)
                   | field_bad("end_of_frame", want.eof, rsp_end_of_frame);
               if (bad) fail_count++;
            end
         end
         if (req_valid && !req_stall) begin
            pixels_seen++;
            predict_pixel(req_pixel, req_start_of_frame);
         end
         // a register write takes effect for the pixels after this edge
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg  = csr_data;
               CSR_FRAME_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
      end
      expected_left = pending_results.size();
   end

endmodule

### sim/sobel_edge_stream_tb.sv
// Top of the sobel_edge_stream testbench: clock, reset, pixel and register stimulus,
// result-side stalls, watchdog and verdict. Checking lives in sobel_edge_stream_checker.
// Depends on ses_pkg, sobel_edge_stream and sobel_edge_stream_checker.
module sobel_edge_stream_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ses_pkg::*;

   localparam int MAX_DIM        = 1024;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int EDGE_ITEMS     = 24;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel;
   logic                 req_start_of_frame;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [COORD_W-1:0]   rsp_out_row;
   logic [COORD_W-1:0]   rsp_out_col;
   logic [PIX_W-1:0]     rsp_grad_x_biased;
   logic [PIX_W-1:0]     rsp_grad_y_biased;
   logic [PIX_W-1:0]     rsp_magnitude;
   logic                 rsp_last_of_run;
   logic                 rsp_end_of_frame;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   int         fail_count;
   int         expected_left;
   int         pixels_seen;
   int         results_seen;
   int         frame_ends;

   idle_mode_type idle_mode = IDLE_NONE;
   int         cur_width = FRAME_WIDTH_RST;
   int         cur_height = FRAME_HEIGHT_RST;
   int         frame_pos = 0;
   int         frame_style = 0;
   int         phases_run = 0;
   int         stuck_cycles = 0;

   sobel_edge_stream #(.MAX_WIDTH(MAX_DIM), .MAX_HEIGHT(MAX_DIM)) uut (.*);

   sobel_edge_stream_checker #(.MAX_WIDTH(MAX_DIM), .MAX_HEIGHT(MAX_DIM)) edge_check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_stall = ($urandom_range(0, 99) < 80);
         IDLE_BOTH:     rsp_stall = ($urandom_range(0, 99) < 7);
         default:       rsp_stall = 1'b0;
      endcase
   end

   // End the run when no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("sobel_edge_stream_tb NOT OK");
         $finish;
      end
   end

   function automatic logic [PIX_W-1:0] shade(int style, int pos);
      case (style)
         0:       return PIX_W'($urandom_range(0, 255));
         1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: return PIX_W'(pos * 37 + $urandom_range(0, 15));
      endcase
   endfunction

   // Wait for every result, then give a pixel with no result time to leave the pipe.
   task automatic settle();
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_index = idx;
      csr_data  = value[CFG_W-1:0];
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] p, input logic sof);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_pixel          = p;
      req_start_of_frame = sof;
      req_valid          = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int width, input int height, input bit set_width,
                            input bit set_height, input idle_mode_type mode, input int n_items,
                            input bit open_frame);
      int w_eff, h_eff, area;
      settle();
      if (set_width) begin
         write_reg(CSR_FRAME_WIDTH, width);
         cur_width = width;
      end
      if (set_height) begin
         write_reg(CSR_FRAME_HEIGHT, height);
         cur_height = height;
      end
      w_eff = (cur_width < MIN_DIM) ? MIN_DIM : (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
      h_eff = (cur_height < MIN_DIM) ? MIN_DIM : (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
      area = w_eff * h_eff;
      idle_mode = mode;
      phases_run++;
      for (int i = 0; i < n_items; i++) begin : one_pixel
         logic sof;
         // mostly well-formed frames; sometimes let the frame wrap, rarely cut it short
         if (i == 0 && open_frame) sof = 1'b1;
         else if (frame_pos >= area) sof = ($urandom_range(0, 99) < 85);
         else sof = ($urandom_range(0, 99) < 3);
         if (sof || frame_pos >= area) begin
            frame_pos   = 0;
            frame_style = $urandom_range(0, 2);
         end
         send_pixel(shade(frame_style, frame_pos), sof);
         frame_pos++;
      end
      req_valid = 1'b0;
   endtask

   initial begin : stimulus
      int w, h;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_pixel          = '0;
      req_start_of_frame = 1'b0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = CSR_FRAME_WIDTH;
      csr_data           = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset size: first row and a few pixels of the second
      run_phase(0, 0, 1'b0, 1'b0, IDLE_NONE, FRAME_WIDTH_RST + 5, 1'b1);

      // smallest frame: full left-minus-right swing, then full top-minus-bottom swing
      // with no start mark (wrap), then a frame cut short by an early start mark
      settle();
      write_reg(CSR_FRAME_WIDTH, MIN_DIM);
      write_reg(CSR_FRAME_HEIGHT, MIN_DIM);
      cur_width  = MIN_DIM;
      cur_height = MIN_DIM;
      phases_run++;
      for (int i = 0; i < 24; i++) begin
         if (i < 9)
            send_pixel((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h00, i == 0);
         else if (i < 18)
            send_pixel((i < 12) ? 8'h00 : (i < 15) ? 8'h80 : 8'hFF, 1'b0);
         else
            send_pixel((i % 2) ? 8'hFF : 8'h00, i == 18 || i == 21);
      end
      req_valid = 1'b0;
      frame_pos = 3;

      // start of the widest and tallest frames, register fields at all-ones and all-zeros
      run_phase(2047, 0, 1'b1, 1'b1, IDLE_NONE, EDGE_ITEMS, 1'b1);
      run_phase(0, 2047, 1'b1, 1'b1, IDLE_BOTH, EDGE_ITEMS, 1'b1);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 9))
            0:       w = $urandom_range(0, 2);
            1:       w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
         run_phase(w, h, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                   idle_mode_type'(ph % 4), $urandom_range(10, 35), $urandom_range(0, 1));
      end

      settle();
      $display("Covered %0d phases: %0d pixels in, %0d results checked, %0d frame ends.",
               phases_run, pixels_seen, results_seen, frame_ends);
      $display("Frames ran from 3x3 to over-range sizes clamped to 1024, under all idling patterns.");
      if (fail_count == 0 && expected_left == 0)
         $display("sobel_edge_stream_tb OK");
      else
         $display("sobel_edge_stream_tb NOT OK");
      $finish;
   end

endmodule
